// ===== rtl/teb_pkg.sv =====
// Shared types and constants of the transparent edge bleed block.
// Pixel and output beat structs, register map codes, queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package teb_pkg;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;

  // Register indexes, decoded from paddr[3:2]
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SMOOTH = 2'd2;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd64;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd64;
  localparam logic                    SMOOTH_RESET = 1'b1;

  // Input kinds carried in tuser
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic   last;
    pixel_t pix;
  } out_beat_t;

  function automatic logic is_opaque(pixel_t p);
    return p.alpha == ALPHA_OPAQUE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/teb_outq.sv =====
// Small output queue that decouples the pixel pipeline from the output stream.
// Depends on teb_pkg (out_beat_t, OUTQ_DEPTH, OUTQ_AW).
`timescale 1ns / 1ps
`default_nettype none

module teb_outq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  teb_pkg::out_beat_t       push_data_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output teb_pkg::out_beat_t       data_o,
  output logic [teb_pkg::OUTQ_AW:0] count_o
);
  import teb_pkg::*;

  out_beat_t            entries_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUTQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUTQ_AW:0]     count_q, count_d;
  logic                 pop_fire;

  assign valid_o  = (count_q != '0);
  assign data_o   = entries_q[rd_ptr_q];
  assign count_o  = count_q;
  assign pop_fire = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i   ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_fire ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (OUTQ_AW+1)'(push_i) - (OUTQ_AW+1)'(pop_fire);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/transparent_edge_bleed_top.sv =====
// Top level of the transparent edge bleed block: config registers, line memory,
// 3x3 window and neighbor selection. Depends on teb_pkg and teb_outq.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata red,green,blue,alpha from bit 0;
//                                               tuser mode
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata red,green,blue,alpha from bit 0;
//                                               tlast
//   apb       in   psel/penable/pwrite, pready  width, height, smoothing enable
//
// One beat per clock in and out while m_axis does not stall. A pixel leaves one row
// and one pixel after it entered (W+1 items, plus the accept stage register and the
// output queue); W+1 drain beats flush a frame. The rate is set by the line memory:
// one read and one write per cycle, the read at accept and the write back next cycle.
// Reset clears counters, window and queue; the line memory needs no clearing.
// A stall on m_axis drops s_axis_tready once the queued beats plus the beat in
// the pipeline reach the four entries of the output queue.
`timescale 1ns / 1ps
`default_nettype none

module transparent_edge_bleed_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [teb_pkg::APB_AW-1:0] paddr,
  input  logic [teb_pkg::APB_DW-1:0] pwdata,
  output logic [teb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // red, green, blue, alpha
  input  logic [0:0]                 s_axis_tuser,  // mode
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // red, green, blue, alpha
  output logic                       m_axis_tlast
);
  import teb_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);   // clamped width
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // clamped height
  localparam int CW = $clog2(MAX_WIDTH);       // column / line memory index
  localparam int RW = $clog2(MAX_HEIGHT) + 1;  // row counter, may pass the last row
  localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;

  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);
  localparam logic [HW-1:0] MaxH = HW'(MAX_HEIGHT);

  typedef struct packed {
    pixel_t          pix;
    logic [CW-1:0]   idx;
    logic            emit;
    logic            last;
    logic            at_top;
    logic            at_bottom;
    logic            at_left;
    logic            at_right;
    logic            smooth;
  } stage_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic                    smooth_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      smooth_q <= SMOOTH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_HEIGHT_W-1:0];
        REG_SMOOTH: smooth_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_SMOOTH: prdata = APB_DW'(smooth_q);
      default:    prdata = '0;
    endcase
  end

  // Clamp dimensions: zero counts as one, oversize saturates
  logic [WW-1:0]    w_cl;
  logic [HW-1:0]    h_cl;
  logic [WW+HW-1:0] frame_px;

  assign w_cl = (width_q == '0) ? WW'(1) :
                ((32'(width_q) > 32'(MAX_WIDTH)) ? MaxW : WW'(width_q));
  assign h_cl = (height_q == '0) ? HW'(1) :
                ((32'(height_q) > 32'(MAX_HEIGHT)) ? MaxH : HW'(height_q));
  assign frame_px = (WW+HW)'(w_cl) * (WW+HW)'(h_cl);

  // ---------------------------------------------------------------------------
  // Accept stage: position counters and read issue
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [EW-1:0] cnt_q;

  logic          s1_valid_q;
  stage_t        s1_q, s1_d;
  logic [OUTQ_AW:0] q_count;

  logic          complete, ignore_beat, take, do_step, wrap, emit, last_hit;
  logic [CW-1:0] ex;
  logic [RW-1:0] ey;

  assign s_axis_tready = (32'(q_count) + 32'(s1_valid_q)) < 32'(OUTQ_DEPTH);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign complete      = 32'(row_q) >= 32'(h_cl);
  // drop a drain that arrives before the frame is fully in
  assign ignore_beat   = (s_axis_tuser[0] == MODE_DRAIN) && !complete;
  assign do_step       = take && !ignore_beat;
  assign wrap          = (32'(col_q) + 32'd1) >= 32'(w_cl);
  assign emit          = (32'(row_q) >= 32'd2) || (row_q == RW'(1) && col_q != '0);
  assign last_hit      = (32'(cnt_q) + 32'd1) >= 32'(frame_px);

  // Position of the centre pixel that this beat finishes
  assign ex = (col_q != '0) ? col_q - 1'b1 : CW'(w_cl - 1'b1);
  assign ey = (col_q != '0) ? row_q - RW'(1) : row_q - RW'(2);

  always_comb begin
    s1_d.pix       = complete ? pixel_t'('0) : pixel_t'(s_axis_tdata);
    s1_d.idx       = col_q;
    s1_d.emit      = emit;
    s1_d.last      = emit && last_hit;
    s1_d.at_top    = (ey == '0);
    s1_d.at_bottom = 32'(ey) >= (32'(h_cl) - 32'd1);
    s1_d.at_left   = (ex == '0);
    s1_d.at_right  = 32'(ex) >= (32'(w_cl) - 32'd1);
    s1_d.smooth    = (w_cl > WW'(1)) && (h_cl > HW'(1)) && smooth_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (do_step) begin
      if (emit && last_hit) begin
        // frame done: restart all positions
        col_q <= '0;
        row_q <= '0;
        cnt_q <= '0;
      end else begin
        col_q <= wrap ? '0 : col_q + 1'b1;
        row_q <= wrap ? row_q + 1'b1 : row_q;
        if (emit) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: per column the two rows above, {newer, older}
  // ---------------------------------------------------------------------------
  logic [63:0] line_mem [MAX_WIDTH];
  logic [63:0] rd_q;
  logic [63:0] fwd_data_q;
  logic        fwd_q;
  logic [63:0] rd_eff;
  logic [63:0] wr_data;
  pixel_t      older, newer;

  // Forward the write back when the next beat reads the same column
  // (single column frames and frame restarts hit this).
  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign older   = pixel_t'(rd_eff[31:0]);
  assign newer   = pixel_t'(rd_eff[63:32]);
  assign wr_data = {s1_q.pix, newer};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_q.idx] <= wr_data;
    end
    if (do_step) begin
      rd_q       <= line_mem[col_q];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= do_step;
      if (do_step) begin
        fwd_q <= s1_valid_q && (s1_q.idx == col_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window: columns left and centre of each row; the right column comes from
  // the line memory read and the input pixel at selection time.
  // ---------------------------------------------------------------------------
  pixel_t up_c_q, up_r_q, mid_c_q, mid_r_q, dn_c_q, dn_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_c_q  <= '0;
      up_r_q  <= '0;
      mid_c_q <= '0;
      mid_r_q <= '0;
      dn_c_q  <= '0;
      dn_r_q  <= '0;
    end else if (s1_valid_q) begin
      up_c_q  <= up_r_q;
      up_r_q  <= older;
      mid_c_q <= mid_r_q;
      mid_r_q <= newer;
      dn_c_q  <= dn_r_q;
      dn_r_q  <= s1_q.pix;
    end
  end

  // Neighbor selection on the shifted window
  pixel_t    centre, src;
  logic      interior;
  out_beat_t beat;

  assign centre   = mid_r_q;
  assign interior = !(s1_q.at_top || s1_q.at_bottom || s1_q.at_left || s1_q.at_right);

  always_comb begin
    src = centre;
    if (centre.alpha == ALPHA_CLEAR && s1_q.smooth) begin
      if (!s1_q.at_top && is_opaque(up_r_q)) begin
        src = up_r_q;                   // up
      end else if (!s1_q.at_left && is_opaque(mid_c_q)) begin
        src = mid_c_q;                  // left
      end else if (!s1_q.at_right && is_opaque(newer)) begin
        src = newer;                    // right
      end else if (interior && is_opaque(up_c_q)) begin
        src = up_c_q;                   // up-left
      end else if (interior && is_opaque(older)) begin
        src = older;                    // up-right
      end else if (interior && is_opaque(dn_c_q)) begin
        src = dn_c_q;                   // down-left
      end else if (interior && is_opaque(s1_q.pix)) begin
        src = s1_q.pix;                 // down-right
      end else if (!s1_q.at_bottom && is_opaque(dn_r_q)) begin
        src = dn_r_q;                   // down
      end
    end
    beat.last      = s1_q.last;
    beat.pix.alpha = centre.alpha;
    beat.pix.blue  = src.blue;
    beat.pix.green = src.green;
    beat.pix.red   = src.red;
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  out_beat_t q_data;

  teb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q && s1_q.emit),
    .push_data_i (beat),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign m_axis_tdata = q_data.pix;
  assign m_axis_tlast = q_data.last;

endmodule

`default_nettype wire

// ===== rtl/teb_checker.sv =====
// Port-level checks of the transparent edge bleed top level, and their bind.
// Depends on transparent_edge_bleed_top.
`timescale 1ns / 1ps
`default_nettype none

module teb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Input back-pressure only while results are waiting downstream
  a_ready_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("s_axis_tready low with no output beat pending");

  // An output beat from an empty queue traces back to an earlier accepted input beat
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output beat appeared without a matching input beat");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind transparent_edge_bleed_top teb_checker u_teb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for transparent_edge_bleed_top: random RGBA frames in, bled pixels out.
// A scoreboard class predicts each output beat; plain tasks drive the streams and APB.
// Depends on teb_pkg and the block's RTL only.

module tb_top;
  import teb_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int MAX_H        = 4096;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either stream
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 16;    // quiet cycles before a register write
  localparam int RANDOM_ITEMS = 1950;

  // Bit-accurate prediction of the bleed, with its own state and registers.
  class bleed_scoreboard;
    pixel_t      line_far  [MAX_W];  // two rows above the input row
    pixel_t      line_near [MAX_W];  // one row above the input row
    pixel_t      win [9];            // 3x3, row major, top row first
    int unsigned col_cnt, row_cnt, emit_cnt;
    int unsigned cfg_w, cfg_h;
    bit          cfg_smooth;
    out_beat_t   bled_pixels [$];
    int          errors;
    int          beats_seen;

    function new();
      foreach (line_far[i]) begin
        line_far[i]  = '0;
        line_near[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      emit_cnt   = 0;
      cfg_w      = WIDTH_RESET;
      cfg_h      = HEIGHT_RESET;
      cfg_smooth = SMOOTH_RESET;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  cfg_w      = value & 32'hFFF;
        REG_HEIGHT: cfg_h      = value & 32'h1FFF;
        REG_SMOOTH: cfg_smooth = value[0];
        default: ;
      endcase
    endfunction

    function void predict_bleed(logic mode, pixel_t px);
      int unsigned w, h, col, row, idx, ex, ey;
      pixel_t      pix, far_px, near_px, centre, colour;
      bit          complete, top, bottom, lft, rgt, found;
      int          order [$];
      out_beat_t   res;
      w = clamp_dim(cfg_w, MAX_W);
      h = clamp_dim(cfg_h, MAX_H);
      complete = (row_cnt >= h);
      // drains only count once the whole frame is in
      if (mode == MODE_DRAIN && !complete) return;
      if (complete) pix = '0;
      else pix = px;
      col = col_cnt;
      row = row_cnt;
      idx = (col < MAX_W) ? col : MAX_W - 1;
      far_px  = line_far[idx];
      near_px = line_near[idx];
      line_far[idx]  = near_px;
      line_near[idx] = pix;
      for (int r = 0; r < 3; r++) begin
        win[r*3]     = win[r*3 + 1];
        win[r*3 + 1] = win[r*3 + 2];
      end
      win[2] = far_px;
      win[5] = near_px;
      win[8] = pix;
      if (col + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row + 1) & 32'h1FFF;
      end else begin
        col_cnt = col + 1;
      end
      if (!(row >= 2 || (row == 1 && col >= 1))) return;

      if (col >= 1) begin
        ex = col - 1;
        ey = row - 1;
      end else begin
        ex = w - 1;
        ey = row - 2;
      end
      centre = win[4];
      colour = centre;
      if (centre.alpha == ALPHA_CLEAR && w > 1 && h > 1 && cfg_smooth) begin
        top    = (ey == 0);
        bottom = (ey >= h - 1);
        lft    = (ex == 0);
        rgt    = (ex >= w - 1);
        // up, left, right, diagonals on interior pixels only, then down
        if (!top) order.push_back(1);
        if (!lft) order.push_back(3);
        if (!rgt) order.push_back(5);
        if (!top && !bottom && !lft && !rgt) begin
          order.push_back(0);
          order.push_back(2);
          order.push_back(6);
          order.push_back(8);
        end
        if (!bottom) order.push_back(7);
        found = 1'b0;
        foreach (order[k]) begin
          if (!found && win[order[k]].alpha == ALPHA_OPAQUE) begin
            colour = win[order[k]];
            found  = 1'b1;
          end
        end
      end
      res.pix       = colour;
      res.pix.alpha = centre.alpha;
      res.last      = (emit_cnt + 1 >= w * h);
      if (res.last) begin
        col_cnt  = 0;
        row_cnt  = 0;
        emit_cnt = 0;
      end else begin
        emit_cnt = (emit_cnt + 1) & 32'hFFFFFF;
      end
      bled_pixels.push_back(res);
    endfunction

    function void check_pixel(out_beat_t got);
      out_beat_t want;
      beats_seen++;
      if (bled_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("beat %0d: unexpected output r=%02h g=%02h b=%02h a=%02h last=%0b",
                   beats_seen, got.pix.red, got.pix.green, got.pix.blue, got.pix.alpha,
                   got.last);
        return;
      end
      want = bled_pixels.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("beat %0d: expected r=%02h g=%02h b=%02h a=%02h last=%0b,",
                   beats_seen, want.pix.red, want.pix.green, want.pix.blue,
                   want.pix.alpha, want.last,
                   " got r=%02h g=%02h b=%02h a=%02h last=%0b",
                   got.pix.red, got.pix.green, got.pix.blue, got.pix.alpha,
                   got.last);
      end
    endfunction

    function int pending();
      return bled_pixels.size();
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr  = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // red, green, blue, alpha (lowest bits first)
  logic [0:0]  s_axis_tuser  = '0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // red, green, blue, alpha (lowest bits first)
  logic        m_axis_tlast;

  bleed_scoreboard sb;
  int  stall_cycles = 0;
  int  items_sent   = 0;
  bit  steady       = 1'b0;  // no idling on either side while set
  bit  hold_req     = 1'b0;

  transparent_edge_bleed_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample both streams at the edge; feed the predictor before checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.predict_bleed(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel({m_axis_tlast, m_axis_tdata});
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("transparent_edge_bleed_top: mismatch");
    $finish;
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 34);
    end
  end

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     pick;
    p = $urandom;
    pick = $urandom_range(9);
    if (pick < 4) p.alpha = ALPHA_CLEAR;
    else if (pick < 8) p.alpha = ALPHA_OPAQUE;
    return p;
  endfunction

  // Offer one beat after a random idle gap; return at the edge that takes it.
  task automatic send_beat(logic mode, pixel_t px);
    if (!steady && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 34) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipeline settle.
  task automatic wait_frame_out();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // One frame of random content: stray drains inside, a mixed flush after.
  task automatic send_frame(int unsigned wreg, int unsigned hreg, bit smooth);
    int unsigned w, h;
    wait_frame_out();
    apb_write(REG_WIDTH, wreg);
    apb_write(REG_HEIGHT, hreg);
    apb_write(REG_SMOOTH, smooth);
    w = sb.clamp_dim(wreg, MAX_W);
    h = sb.clamp_dim(hreg, MAX_H);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 4) send_beat(MODE_DRAIN, rand_pixel());
      send_beat(MODE_PIXEL, rand_pixel());
    end
    // flush: a pixel past the frame end acts as a drain
    for (int unsigned i = 0; i <= w; i++)
      send_beat(($urandom_range(99) < 70) ? MODE_DRAIN : MODE_PIXEL, rand_pixel());
    repeat ($urandom_range(2)) send_beat(MODE_DRAIN, rand_pixel());
  endtask

  initial begin
    pixel_t      grid [9];
    int unsigned wreg, hreg, pick;
    int          frame_no;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a drain with no frame in flight is ignored.
    send_beat(MODE_DRAIN, 32'hFFFF_FFFF);
    wait_frame_out();

    // 3x3 smoothed: corner, edges, interior, a partly transparent pass-through.
    // Layout per word: alpha, blue, green, red.
    grid = '{32'h0056_3412, 32'hFFFF_00FF, 32'h8080_8080,
             32'hFF00_FF00, 32'h00FF_FFFF, 32'hFF03_0201,
             32'h0000_0000, 32'hFFFF_FFFF, 32'h00AA_55AA};
    apb_write(REG_WIDTH, 3);
    apb_write(REG_HEIGHT, 3);
    apb_write(REG_SMOOTH, 1);
    foreach (grid[i]) send_beat(MODE_PIXEL, grid[i]);
    send_beat(MODE_DRAIN, 32'h0000_0000);
    send_beat(MODE_PIXEL, 32'hFFFF_FFFF);
    send_beat(MODE_DRAIN, 32'h1234_5678);
    send_beat(MODE_PIXEL, 32'h0000_0000);
    wait_frame_out();

    // Zero width and height read as one: a 1x1 frame.
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 0);
    send_beat(MODE_PIXEL, 32'h00FF_FFFF);
    send_beat(MODE_DRAIN, 32'h0000_0000);
    send_beat(MODE_DRAIN, 32'hFFFF_FFFF);
    wait_frame_out();

    // 2x2 with smoothing off passes clear pixels through.
    apb_write(REG_WIDTH, 2);
    apb_write(REG_HEIGHT, 2);
    apb_write(REG_SMOOTH, 0);
    send_beat(MODE_PIXEL, 32'h00AB_CDEF);
    send_beat(MODE_PIXEL, 32'hFF00_0000);
    send_beat(MODE_PIXEL, 32'hFFFF_FFFF);
    send_beat(MODE_PIXEL, 32'h0000_0000);
    repeat (3) send_beat(MODE_DRAIN, 32'h0000_0000);

    // Long receiver hold-off while input keeps coming: fill the block up.
    wait_frame_out();
    hold_req = 1'b1;
    send_frame(40, 6, 1);

    frame_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (frame_no >= 6 && frame_no < 11);
      pick = $urandom_range(99);
      if (pick < 5) wreg = $urandom_range(1);
      else if (pick < 20) wreg = $urandom_range(70, 13);
      else wreg = $urandom_range(12, 1);
      pick = $urandom_range(99);
      if (pick < 10) hreg = $urandom_range(1);
      else hreg = $urandom_range(8, 1);
      send_frame(wreg, hreg, $urandom_range(99) < 85);
      frame_no++;
    end
    steady = 1'b0;

    wait_frame_out();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("transparent_edge_bleed_top: match");
    else
      $display("transparent_edge_bleed_top: mismatch");
    $finish;
  end

endmodule
